// File: sv/tgi_pkg.sv
// Shared constants, types and helper functions of the trilinear grid interpolator.
package tgi_pkg;

    localparam int AXIS_BITS_DEF    = 5;
    localparam int GRID_DEPTH_DEF   = 32768;
    localparam int SAMPLE_WIDTH_DEF = 32;

    localparam int COORD_W    = 32;
    localparam int NODE_W     = 5;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // Axis fraction is signed Q.16 in [-4, 1), weights are 1 - f or f.
    localparam int FRAC_W  = 19;
    localparam int WGT_W   = 20;
    localparam int ONE_Q16 = 65536;
    localparam int FRAC_SAT_MAG = 262144;

    localparam int N_BANKS   = 8;
    localparam int N_STAGES  = 11;
    localparam int ROW_MAX_W = 24;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_ORIGIN_X   = 3'd0,
        CFG_ORIGIN_Y   = 3'd1,
        CFG_ORIGIN_Z   = 3'd2,
        CFG_INV_STEP_X = 3'd3,
        CFG_INV_STEP_Y = 3'd4,
        CFG_INV_STEP_Z = 3'd5,
        CFG_GRID_LAST  = 3'd6
    } t_cfg_idx;

    // Row inside a parity bank: the node indices without their low bits, z highest.
    function automatic logic [ROW_MAX_W-1:0] bank_row(input logic [7:0] x, input logic [7:0] y,
                                                      input logic [7:0] z, input int a);
        logic [ROW_MAX_W-1:0] xh;
        logic [ROW_MAX_W-1:0] yh;
        logic [ROW_MAX_W-1:0] zh;
        xh = ROW_MAX_W'(x >> 1);
        yh = ROW_MAX_W'(y >> 1);
        zh = ROW_MAX_W'(z >> 1);
        return (zh << (2 * (a - 1))) | (xh << (a - 1)) | yh;
    endfunction

endpackage

// File: sv/tgi_channels.sv
// Handshake channel interfaces: request, response and configuration write.
interface tgi_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [4:0]  node_x;
    logic [4:0]  node_y;
    logic [4:0]  node_z;
    logic [31:0] node_value;
    logic [31:0] point_x;
    logic [31:0] point_y;
    logic [31:0] point_z;

    modport source (output valid, req_type, node_x, node_y, node_z, node_value,
                    point_x, point_y, point_z, input ready);
    modport sink (input valid, req_type, node_x, node_y, node_z, node_value,
                  point_x, point_y, point_z, output ready);
endinterface

interface tgi_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] interp_value;
    logic        saturated;

    modport source (output valid, interp_value, saturated, input ready);
    modport sink (input valid, interp_value, saturated, output ready);
endinterface

interface tgi_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  addr;
    logic [31:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink (input valid, addr, data, output ready);
endinterface

// File: sv/tgi_bank.sv
// One parity bank of the grid store: single write port, registered read port.
module tgi_bank #(
    parameter int ROW_W  = 12,
    parameter int DATA_W = 32
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ROW_W-1:0]  i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ROW_W-1:0]  i_raddr,
    output logic [DATA_W-1:0] o_q
);

    logic [DATA_W-1:0] mem [2**ROW_W];
    logic [DATA_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_q <= mem[i_raddr];
        end
    end

    assign o_q = r_q;

endmodule

// File: sv/tgi_grid.sv
// Grid store split into eight banks by the parity of x, y and z, so all corners read at once.
module tgi_grid #(
    parameter int AXIS_BITS    = tgi_pkg::AXIS_BITS_DEF,
    parameter int GRID_DEPTH   = tgi_pkg::GRID_DEPTH_DEF,
    parameter int SAMPLE_WIDTH = tgi_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [AXIS_BITS-1:0]           i_wx,
    input  logic [AXIS_BITS-1:0]           i_wy,
    input  logic [AXIS_BITS-1:0]           i_wz,
    input  logic signed [SAMPLE_WIDTH-1:0] i_wdata,
    input  logic                           i_re,
    input  logic [AXIS_BITS-1:0]           i_xl,
    input  logic [AXIS_BITS-1:0]           i_xu,
    input  logic [AXIS_BITS-1:0]           i_yl,
    input  logic [AXIS_BITS-1:0]           i_yu,
    input  logic [AXIS_BITS-1:0]           i_zl,
    input  logic [AXIS_BITS-1:0]           i_zu,
    output logic signed [SAMPLE_WIDTH-1:0] o_q [tgi_pkg::N_BANKS]
);

    localparam int ROW_W = $clog2(GRID_DEPTH / tgi_pkg::N_BANKS);

    logic [ROW_W-1:0] waddr;

    assign waddr = ROW_W'(tgi_pkg::bank_row(8'(i_wx), 8'(i_wy), 8'(i_wz), AXIS_BITS));

    for (genvar b = 0; b < tgi_pkg::N_BANKS; b++) begin : g_bank
        logic [AXIS_BITS-1:0] xs;
        logic [AXIS_BITS-1:0] ys;
        logic [AXIS_BITS-1:0] zs;
        logic [ROW_W-1:0]     raddr;
        logic                 we;
        logic [SAMPLE_WIDTH-1:0] q;

        // Bank b holds nodes with z parity b[2], x parity b[1], y parity b[0].
        assign xs = (i_xl[0] == b[1]) ? i_xl : i_xu;
        assign ys = (i_yl[0] == b[0]) ? i_yl : i_yu;
        assign zs = (i_zl[0] == b[2]) ? i_zl : i_zu;
        assign raddr = ROW_W'(tgi_pkg::bank_row(8'(xs), 8'(ys), 8'(zs), AXIS_BITS));
        assign we = i_we && (i_wz[0] == b[2]) && (i_wx[0] == b[1]) && (i_wy[0] == b[0]);

        tgi_bank #(
            .ROW_W  (ROW_W),
            .DATA_W (SAMPLE_WIDTH)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (we),
            .i_waddr (waddr),
            .i_wdata (i_wdata),
            .i_re    (i_re),
            .i_raddr (raddr),
            .o_q     (q)
        );

        assign o_q[b] = $signed(q);
    end

endmodule

// File: sv/tgi_axis.sv
// Per-axis front end: origin offset, reciprocal-step scaling, corner indices and fraction.
module tgi_axis #(
    parameter int AXIS_BITS = tgi_pkg::AXIS_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic [2:0]                       i_ld,
    input  logic [tgi_pkg::COORD_W-1:0]      i_point,
    input  logic [tgi_pkg::COORD_W-1:0]      i_origin,
    input  logic [tgi_pkg::COORD_W-1:0]      i_inv_step,
    input  logic [AXIS_BITS-1:0]             i_last,
    output logic [AXIS_BITS-1:0]             o_lower,
    output logic [AXIS_BITS-1:0]             o_upper,
    output logic signed [tgi_pkg::FRAC_W-1:0] o_frac,
    output logic                             o_sat
);

    localparam int FW = tgi_pkg::FRAC_W;

    logic signed [32:0] d;
    logic [31:0]        mag;
    logic [63:0]        prod;
    logic               r1_neg;
    logic [31:0]        r1_mag;
    logic               r2_neg;
    logic [63:0]        r2_prod;

    logic                 below;
    logic [31:0]          ip;
    logic [AXIS_BITS-1:0] lower;
    logic [AXIS_BITS-1:0] upper;
    logic [64:0]          rnd;
    logic [48:0]          ceil_mag;
    logic signed [FW-1:0] frac;
    logic                 sat;

    // The offset never reaches 2**32 in magnitude, so 32 bits hold it.
    assign d    = $signed({i_point[31], i_point}) - $signed({i_origin[31], i_origin});
    assign mag  = d[32] ? 32'(-d) : d[31:0];
    assign prod = r1_mag * i_inv_step;

    always_ff @(posedge i_clk) begin
        if (i_ld[0]) begin
            r1_neg <= d[32];
            r1_mag <= mag;
        end
        if (i_ld[1]) begin
            r2_neg  <= r1_neg;
            r2_prod <= prod;
        end
    end

    always_comb begin
        below    = r2_neg && (r2_prod != 64'd0);
        ip       = r2_prod[63:32];
        lower    = below ? '0 : ((ip > 32'(i_last)) ? i_last : ip[AXIS_BITS-1:0]);
        upper    = (lower == i_last) ? i_last : lower + 1'b1;
        rnd      = {1'b0, r2_prod} + 65'd65535;
        ceil_mag = rnd[64:16];
        frac     = '0;
        sat      = 1'b0;
        if (upper == lower || i_inv_step == '0) begin
            frac = '0;
        end else if (below) begin
            // Below the grid the fraction is the negated ceiling, limited to -4.
            if (ceil_mag > 49'(tgi_pkg::FRAC_SAT_MAG)) begin
                frac = FW'(-tgi_pkg::FRAC_SAT_MAG);
                sat  = 1'b1;
            end else begin
                frac = -$signed(ceil_mag[FW-1:0]);
            end
        end else begin
            frac = $signed({3'b000, r2_prod[31:16]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld[2]) begin
            o_lower <= lower;
            o_upper <= upper;
            o_frac  <= frac;
            o_sat   <= sat;
        end
    end

endmodule

// File: sv/tgi_accum.sv
// Corner weights, weighted samples, adder tree, rounding to Q16.16 and saturation.
module tgi_accum #(
    parameter int SAMPLE_WIDTH = tgi_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic [7:0]                        i_ld,
    input  logic signed [tgi_pkg::FRAC_W-1:0] i_frac_x,
    input  logic signed [tgi_pkg::FRAC_W-1:0] i_frac_y,
    input  logic signed [tgi_pkg::FRAC_W-1:0] i_frac_z,
    input  logic [5:0]                        i_par,
    input  logic                              i_sat,
    input  logic signed [SAMPLE_WIDTH-1:0]    i_bank_q [tgi_pkg::N_BANKS],
    output logic [31:0]                       o_value,
    output logic                              o_sat
);

    localparam int WW    = tgi_pkg::WGT_W;
    localparam int W3_W  = 60;
    localparam int LO_W  = 30;
    localparam int ACC_W = SAMPLE_WIDTH + 58;
    localparam int PL_W  = SAMPLE_WIDTH + LO_W + 1;
    localparam int PH_W  = SAMPLE_WIDTH + W3_W - LO_W;

    logic signed [WW-1:0] wx [2];
    logic signed [WW-1:0] wy [2];
    logic signed [WW-1:0] wz [2];

    logic signed [2*WW-1:0] r4_wxy [4];
    logic signed [WW-1:0]   r4_wz  [2];
    logic [5:0]             r4_par;
    logic signed [W3_W-1:0]         r5_w [8];
    logic signed [SAMPLE_WIDTH-1:0] r5_s [8];
    logic signed [PL_W-1:0]  r6_plo [8];
    logic signed [PH_W-1:0]  r6_phi [8];
    logic signed [ACC_W-1:0] r7_t [8];
    logic signed [ACC_W-1:0] r8_s [4];
    logic signed [ACC_W-1:0] r9_s [2];
    logic signed [ACC_W-1:0] r10_s;
    logic [10:4]             r_sat;
    logic signed [ACC_W-1:0] rounded;
    logic signed [ACC_W-1:0] max_v;
    logic signed [ACC_W-1:0] min_v;

    assign wx[0] = WW'(tgi_pkg::ONE_Q16) - WW'(i_frac_x);
    assign wx[1] = WW'(i_frac_x);
    assign wy[0] = WW'(tgi_pkg::ONE_Q16) - WW'(i_frac_y);
    assign wy[1] = WW'(i_frac_y);
    assign wz[0] = WW'(tgi_pkg::ONE_Q16) - WW'(i_frac_z);
    assign wz[1] = WW'(i_frac_z);

    always_ff @(posedge i_clk) begin
        if (i_ld[0]) begin
            for (int c = 0; c < 4; c++) begin
                r4_wxy[c] <= wx[c % 2] * wy[c / 2];
            end
            r4_wz[0] <= wz[0];
            r4_wz[1] <= wz[1];
            r4_par   <= i_par;
        end
    end

    // i_par holds {z upper, z lower, y upper, y lower, x upper, x lower} parities.
    always_ff @(posedge i_clk) begin
        if (i_ld[1]) begin
            for (int c = 0; c < 8; c++) begin
                logic xp;
                logic yp;
                logic zp;
                xp = r4_par[c % 2];
                yp = r4_par[2 + (c / 2) % 2];
                zp = r4_par[4 + c / 4];
                r5_w[c] <= r4_wxy[c % 4] * r4_wz[c / 4];
                r5_s[c] <= i_bank_q[{zp, xp, yp}];
            end
        end
    end

    // The weight spans more than 32 bits, so each product is formed in two halves.
    always_ff @(posedge i_clk) begin
        if (i_ld[2]) begin
            for (int c = 0; c < 8; c++) begin
                r6_plo[c] <= r5_s[c] * $signed({1'b0, r5_w[c][LO_W-1:0]});
                r6_phi[c] <= r5_s[c] * $signed(r5_w[c][W3_W-1:LO_W]);
            end
        end
        if (i_ld[3]) begin
            for (int c = 0; c < 8; c++) begin
                r7_t[c] <= (ACC_W'(r6_phi[c]) <<< LO_W) + ACC_W'(r6_plo[c]);
            end
        end
        if (i_ld[4]) begin
            for (int c = 0; c < 4; c++) begin
                r8_s[c] <= r7_t[2 * c] + r7_t[2 * c + 1];
            end
        end
        if (i_ld[5]) begin
            r9_s[0] <= r8_s[0] + r8_s[1];
            r9_s[1] <= r8_s[2] + r8_s[3];
        end
        if (i_ld[6]) begin
            r10_s <= r9_s[0] + r9_s[1] + (ACC_W'(1) <<< 47);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld[0]) r_sat[4] <= i_sat;
        for (int k = 5; k <= 10; k++) begin
            if (i_ld[k - 4]) r_sat[k] <= r_sat[k - 1];
        end
    end

    assign rounded = r10_s >>> 48;
    assign max_v   = $signed({{(ACC_W - 32){1'b0}}, 32'h7FFF_FFFF});
    assign min_v   = $signed({{(ACC_W - 32){1'b1}}, 32'h8000_0000});

    always_ff @(posedge i_clk) begin
        if (i_ld[7]) begin
            if (rounded > max_v) begin
                o_value <= 32'h7FFF_FFFF;
                o_sat   <= 1'b1;
            end else if (rounded < min_v) begin
                o_value <= 32'h8000_0000;
                o_sat   <= 1'b1;
            end else begin
                o_value <= rounded[31:0];
                o_sat   <= r_sat[10];
            end
        end
    end

endmodule

// File: sv/trilinear_grid_interpolator.sv
// Top level of the trilinear grid interpolator: configuration, pipeline control and datapath.
// The block takes one transaction per clock while o_rsp is not stalling and answers each query
// from its last stage; a node write leaves the pipeline after stage 4 and yields no response.
// Stages 1 to 3 offset, scale and decode each axis, stage 4 writes or reads the grid, which
// is split into eight parity banks of GRID_DEPTH/8 entries so that all eight corners come
// from a single read, and stages 5 to 11 form the weights, the products in two halves, a
// three-level adder tree and the rounded, saturated result. Stalls propagate stage by
// stage, so empty stages keep filling while a response waits. GRID_DEPTH is a power of two
// of at least 2**(3*AXIS_BITS); the store is not cleared, and a query must only touch
// nodes that were written.
module trilinear_grid_interpolator #(
    parameter int AXIS_BITS    = tgi_pkg::AXIS_BITS_DEF,
    parameter int GRID_DEPTH   = tgi_pkg::GRID_DEPTH_DEF,
    parameter int SAMPLE_WIDTH = tgi_pkg::SAMPLE_WIDTH_DEF
) (
    input logic          i_clk,
    input logic          i_rst_n,
    tgi_req_if.sink      i_req,
    tgi_rsp_if.source    o_rsp,
    tgi_cfg_if.sink      i_cfg
);

    localparam int NS = tgi_pkg::N_STAGES;
    localparam int A  = AXIS_BITS;

    logic [31:0]    r_origin_x, r_origin_y, r_origin_z;
    logic [31:0]    r_inv_x, r_inv_y, r_inv_z;
    logic [3*A-1:0] r_last;

    logic [NS:1] r_vld;
    logic [NS:1] ld;
    logic [3:1]  r_qry;
    logic [A-1:0] r_wx [3:1];
    logic [A-1:0] r_wy [3:1];
    logic [A-1:0] r_wz [3:1];
    logic signed [SAMPLE_WIDTH-1:0] r_wdata [3:1];

    logic [A-1:0] xl, xu, yl, yu, zl, zu;
    logic signed [tgi_pkg::FRAC_W-1:0] fx, fy, fz;
    logic sx, sy, sz;
    logic grid_we;
    logic signed [SAMPLE_WIDTH-1:0] bank_q [tgi_pkg::N_BANKS];

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_origin_z <= '0;
            r_inv_x    <= 32'd65536;
            r_inv_y    <= 32'd65536;
            r_inv_z    <= 32'd65536;
            r_last     <= '1;
        end else if (i_cfg.valid) begin
            unique case (tgi_pkg::t_cfg_idx'(i_cfg.addr))
                tgi_pkg::CFG_ORIGIN_X:   r_origin_x <= i_cfg.data;
                tgi_pkg::CFG_ORIGIN_Y:   r_origin_y <= i_cfg.data;
                tgi_pkg::CFG_ORIGIN_Z:   r_origin_z <= i_cfg.data;
                tgi_pkg::CFG_INV_STEP_X: r_inv_x    <= i_cfg.data;
                tgi_pkg::CFG_INV_STEP_Y: r_inv_y    <= i_cfg.data;
                tgi_pkg::CFG_INV_STEP_Z: r_inv_z    <= i_cfg.data;
                tgi_pkg::CFG_GRID_LAST:  r_last     <= i_cfg.data[3*A-1:0];
                default: ;
            endcase
        end
    end

    // A stage loads when it is empty or its content moves on in the same cycle.
    always_comb begin
        ld[NS] = !r_vld[NS] || o_rsp.ready;
        for (int k = NS - 1; k >= 1; k--) begin
            ld[k] = !r_vld[k] || ld[k + 1];
        end
    end

    assign i_req.ready = ld[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (ld[1]) r_vld[1] <= i_req.valid;
            if (ld[2]) r_vld[2] <= r_vld[1];
            if (ld[3]) r_vld[3] <= r_vld[2];
            // Node writes end in the grid store and do not travel further.
            if (ld[4]) r_vld[4] <= r_vld[3] && r_qry[3];
            for (int k = 5; k <= NS; k++) begin
                if (ld[k]) r_vld[k] <= r_vld[k - 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld[1]) begin
            r_qry[1]   <= i_req.req_type;
            r_wx[1]    <= A'(i_req.node_x);
            r_wy[1]    <= A'(i_req.node_y);
            r_wz[1]    <= A'(i_req.node_z);
            r_wdata[1] <= SAMPLE_WIDTH'($signed(i_req.node_value));
        end
        for (int k = 2; k <= 3; k++) begin
            if (ld[k]) begin
                r_qry[k]   <= r_qry[k - 1];
                r_wx[k]    <= r_wx[k - 1];
                r_wy[k]    <= r_wy[k - 1];
                r_wz[k]    <= r_wz[k - 1];
                r_wdata[k] <= r_wdata[k - 1];
            end
        end
    end

    tgi_axis #(.AXIS_BITS(A)) u_axis_x (
        .i_clk      (i_clk),
        .i_ld       (ld[3:1]),
        .i_point    (i_req.point_x),
        .i_origin   (r_origin_x),
        .i_inv_step (r_inv_x),
        .i_last     (r_last[A-1:0]),
        .o_lower    (xl),
        .o_upper    (xu),
        .o_frac     (fx),
        .o_sat      (sx)
    );

    tgi_axis #(.AXIS_BITS(A)) u_axis_y (
        .i_clk      (i_clk),
        .i_ld       (ld[3:1]),
        .i_point    (i_req.point_y),
        .i_origin   (r_origin_y),
        .i_inv_step (r_inv_y),
        .i_last     (r_last[2*A-1:A]),
        .o_lower    (yl),
        .o_upper    (yu),
        .o_frac     (fy),
        .o_sat      (sy)
    );

    tgi_axis #(.AXIS_BITS(A)) u_axis_z (
        .i_clk      (i_clk),
        .i_ld       (ld[3:1]),
        .i_point    (i_req.point_z),
        .i_origin   (r_origin_z),
        .i_inv_step (r_inv_z),
        .i_last     (r_last[3*A-1:2*A]),
        .o_lower    (zl),
        .o_upper    (zu),
        .o_frac     (fz),
        .o_sat      (sz)
    );

    assign grid_we = ld[4] && r_vld[3] && !r_qry[3];

    tgi_grid #(
        .AXIS_BITS    (A),
        .GRID_DEPTH   (GRID_DEPTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (grid_we),
        .i_wx    (r_wx[3]),
        .i_wy    (r_wy[3]),
        .i_wz    (r_wz[3]),
        .i_wdata (r_wdata[3]),
        .i_re    (ld[4]),
        .i_xl    (xl),
        .i_xu    (xu),
        .i_yl    (yl),
        .i_yu    (yu),
        .i_zl    (zl),
        .i_zu    (zu),
        .o_q     (bank_q)
    );

    tgi_accum #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_accum (
        .i_clk    (i_clk),
        .i_ld     (ld[NS:4]),
        .i_frac_x (fx),
        .i_frac_y (fy),
        .i_frac_z (fz),
        .i_par    ({zu[0], zl[0], yu[0], yl[0], xu[0], xl[0]}),
        .i_sat    (sx || sy || sz),
        .i_bank_q (bank_q),
        .o_value  (o_rsp.interp_value),
        .o_sat    (o_rsp.saturated)
    );

    assign o_rsp.valid = r_vld[NS];

    // Input back-pressure only appears when every stage holds a transaction.
    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req.ready |-> (&r_vld))
        else $error("request stalled with an empty pipeline stage");

    // A node write never continues past the grid stage.
    a_write_retires: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ld[4] && r_vld[3] && !r_qry[3]) |=> !r_vld[4])
        else $error("node write entered the result pipeline");

    // A held response stage keeps its transaction.
    a_hold_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NS] && !o_rsp.ready) |=> r_vld[NS] && $stable(o_rsp.interp_value))
        else $error("stalled response was lost");

endmodule
